// ----- sv/zsma_pkg.sv -----
// Shared types and constants for the zero-skipping moving average unit.
`default_nettype none

package zsma_pkg;

    localparam int CHAN_W   = 2;
    localparam int SAMPLE_W = 16;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_UPDATE = 6'b000100,
        S_LAUNCH = 6'b001000,
        S_DIV    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    typedef struct packed {
        logic load_in;
        logic update;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- sv/zsma_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module zsma_div #(
    parameter int SUM_W = 20,
    parameter int CNT_W = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [SUM_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [SUM_W-1:0]      o_quotient
);
    localparam int IW = $clog2(SUM_W);

    logic [SUM_W-1:0] r_q;
    logic [CNT_W-1:0] r_rem;
    logic [CNT_W-1:0] r_div;
    logic [IW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [CNT_W:0]   shifted;
    logic [CNT_W:0]   diff;
    logic             qbit;

    always_comb begin
        shifted = {r_rem, r_q[SUM_W-1]};
        diff    = shifted - {1'b0, r_div};
        qbit    = (shifted >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + IW'(1);
                if (r_cnt == IW'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_W-2:0], qbit};
            r_rem <= qbit ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

// ----- sv/zsma_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
`default_nettype none

module zsma_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire zsma_pkg::t_sts i_sts,
    output zsma_pkg::t_cmd      o_cmd
);
    import zsma_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_LAUNCH;
            end
            S_LAUNCH: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- sv/zsma_dp.sv -----
// Datapath with sample memory, running sums and counts, divider and output register.
`default_nettype none

module zsma_dp #(
    parameter int WINDOW   = 15,
    parameter int CHANNELS = 3
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic [zsma_pkg::CHAN_W-1:0]        i_channel,
    input  wire logic [zsma_pkg::SAMPLE_W-1:0]      i_sample,
    input  wire logic                               i_stall,
    output logic                                    o_valid,
    output logic [zsma_pkg::CHAN_W-1:0]             o_channel_out,
    output logic [zsma_pkg::SAMPLE_W-1:0]           o_average,
    output logic                                    o_sample_error,
    input  wire zsma_pkg::t_cmd                     i_cmd,
    output zsma_pkg::t_sts                          o_sts
);
    import zsma_pkg::*;

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int PW    = $clog2(WINDOW);
    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = $clog2(DEPTH);

    logic [SAMPLE_W-1:0] mem [DEPTH];

    logic [CHAN_W-1:0]   r_chan;
    logic [SAMPLE_W-1:0] r_sample;
    logic [CH_W-1:0]     r_idx;
    logic                r_inr;
    logic [SAMPLE_W-1:0] r_rd;

    logic [PW-1:0]       r_ptr  [CHANNELS];
    logic [CNT_W-1:0]    r_fill [CHANNELS];
    logic [SUM_W-1:0]    r_sum  [CHANNELS];
    logic [CNT_W-1:0]    r_cnt  [CHANNELS];

    logic                r_o_valid;
    logic [CHAN_W-1:0]   r_o_chan;
    logic [SAMPLE_W-1:0] r_o_avg;
    logic                r_o_err;

    logic [CH_W+1:0]     ch_ext;
    logic                in_range;
    logic [AW-1:0]       addr;
    logic [SAMPLE_W-1:0] old;
    logic [SUM_W-1:0]    n_sum;
    logic [CNT_W-1:0]    n_cnt;
    logic                div_done;
    logic [SUM_W-1:0]    quotient;

    always_comb begin
        ch_ext   = (CH_W + 2)'(i_channel);
        in_range = (ch_ext < (CH_W + 2)'(CHANNELS));
        addr     = AW'(r_idx) * AW'(WINDOW) + AW'(r_ptr[r_idx]);
        old      = (r_fill[r_idx] == CNT_W'(WINDOW)) ? r_rd : '0;
        n_sum    = r_sum[r_idx] - SUM_W'(old) + SUM_W'(r_sample);
        n_cnt    = r_cnt[r_idx] - CNT_W'(old != '0) + CNT_W'(r_sample != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_chan   <= i_channel;
            r_sample <= i_sample;
            r_idx    <= in_range ? ch_ext[CH_W-1:0] : '0;
            r_inr    <= in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && r_inr) begin
            mem[addr] <= r_sample;
        end
        r_rd <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_ptr[c]  <= '0;
                r_fill[c] <= '0;
                r_sum[c]  <= '0;
                r_cnt[c]  <= '0;
            end
        end else if (i_cmd.update && r_inr) begin
            r_ptr[r_idx] <= (r_ptr[r_idx] == PW'(WINDOW - 1)) ? '0 : r_ptr[r_idx] + PW'(1);
            if (r_fill[r_idx] != CNT_W'(WINDOW)) begin
                r_fill[r_idx] <= r_fill[r_idx] + CNT_W'(1);
            end
            r_sum[r_idx] <= n_sum;
            r_cnt[r_idx] <= n_cnt;
        end
    end

    zsma_div #(
        .SUM_W(SUM_W),
        .CNT_W(CNT_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_dividend(r_sum[r_idx]),
        .i_divisor (r_cnt[r_idx]),
        .o_done    (div_done),
        .o_quotient(quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_chan <= r_chan;
            r_o_err  <= (r_sample == '0);
            r_o_avg  <= (r_inr && r_cnt[r_idx] != '0) ? quotient[SAMPLE_W-1:0] : '0;
        end
    end

    assign o_sts.div_done = div_done;
    assign o_sts.out_free = !r_o_valid || !i_stall;

    assign o_valid        = r_o_valid;
    assign o_channel_out  = r_o_chan;
    assign o_average      = r_o_avg;
    assign o_sample_error = r_o_err;

endmodule

`default_nettype wire

// ----- sv/zero_skipping_moving_average_unit.sv -----
// Top level of the per-channel moving average that skips zero samples.
//
//   Channel  Direction  Handshake           Payload
//   input    in         i_valid / o_stall   i_channel, i_sample
//   output   out        o_valid / i_stall   o_channel_out, o_average, o_sample_error
//
// The time from acceptance to the result register depends on WINDOW, through
// SUM_W = 16 + clog2(WINDOW+1), the quotient width that the divider works through.
// The divider produces one quotient bit per cycle and handles one request at a time.
// Reset is synchronous and clears every window, so no clearing pass is needed.
// A stalled result waits in the output register while the next request is being worked on.
`default_nettype none

module zero_skipping_moving_average_unit #(
    parameter int WINDOW   = 15,
    parameter int CHANNELS = 3
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [zsma_pkg::CHAN_W-1:0]   i_channel,
    input  wire logic [zsma_pkg::SAMPLE_W-1:0] i_sample,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [zsma_pkg::CHAN_W-1:0]        o_channel_out,
    output logic [zsma_pkg::SAMPLE_W-1:0]      o_average,
    output logic                               o_sample_error
);
    import zsma_pkg::*;

    t_cmd cmd;
    t_sts sts;

    zsma_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_sts  (sts),
        .o_cmd  (cmd)
    );

    zsma_dp #(
        .WINDOW  (WINDOW),
        .CHANNELS(CHANNELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_channel     (i_channel),
        .i_sample      (i_sample),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_channel_out (o_channel_out),
        .o_average     (o_average),
        .o_sample_error(o_sample_error),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

`default_nettype wire

// ----- sv/zsma_check.sv -----
// Port-level checker for the moving average unit and its bind statement.
`default_nettype none

module zsma_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [1:0]  i_channel,
    input wire logic [15:0] i_sample,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_channel_out,
    input wire logic [15:0] o_average,
    input wire logic        o_sample_error
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_channel) && $stable(i_sample))
        else $error("Stalled request changed or was withdrawn.");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("Stalled result was dropped.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_average) && $stable(o_channel_out)
            && $stable(o_sample_error))
        else $error("Stalled result changed.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall ##1 o_stall)
        else $error("Input was not stalled while a request is in work.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("Reset did not clear the handshakes.");

endmodule

bind zero_skipping_moving_average_unit zsma_check u_check (.*);

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the zero-skipping moving average unit.
`timescale 1ns / 1ps

module testbench;

    import zsma_pkg::*;

    localparam int WINDOW      = 15;
    localparam int CHANNELS    = 3;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 350;

    typedef logic [CHAN_W-1:0]   chan_t;
    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        chan_t   channel;
        sample_t average;
        logic    error;
    } avg_result_t;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    in_valid = 1'b0;
    chan_t   in_channel = '0;
    sample_t in_sample = '0;
    logic    out_stall = 1'b0;
    logic    o_stall;
    logic    o_valid;
    chan_t   o_channel_out;
    sample_t o_average;
    logic    o_sample_error;

    sample_t     chan_window [CHANNELS][WINDOW];
    avg_result_t expected_avg_q [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int sent_count     = 0;
    int checked_count  = 0;
    int cycle_count    = 0;

    zero_skipping_moving_average_unit #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (in_valid),
        .o_stall        (o_stall),
        .i_channel      (in_channel),
        .i_sample       (in_sample),
        .o_valid        (o_valid),
        .i_stall        (out_stall),
        .o_channel_out  (o_channel_out),
        .o_average      (o_average),
        .o_sample_error (o_sample_error)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic avg_result_t predict_mean(input chan_t ch, input sample_t s);
        avg_result_t r;
        logic [31:0] total;
        logic [31:0] used;
        int          i;
        r.channel = ch;
        r.error   = (s == '0);
        r.average = '0;
        total     = '0;
        used      = '0;
        if (ch < CHANNELS) begin
            for (i = 0; i < WINDOW - 1; i++) begin
                chan_window[ch][i] = chan_window[ch][i + 1];
            end
            chan_window[ch][WINDOW - 1] = s;
            for (i = 0; i < WINDOW; i++) begin
                if (chan_window[ch][i] != '0) begin
                    total += chan_window[ch][i];
                    used++;
                end
            end
            if (used != 0) begin
                r.average = sample_t'(total / used);
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : check_results
        avg_result_t want;
        if (i_rst_n && o_valid && !out_stall) begin
            if (expected_avg_q.size() == 0) begin
                $error("Result with no request pending: channel_out %0d average %0d",
                       o_channel_out, o_average);
                fail_count++;
            end else begin
                want = expected_avg_q.pop_front();
                checked_count++;
                if (o_channel_out !== want.channel) begin
                    $error("channel_out: expected %0d, actual %0d", want.channel,
                           o_channel_out);
                    fail_count++;
                end
                if (o_average !== want.average) begin
                    $error("average: expected %0d, actual %0d", want.average, o_average);
                    fail_count++;
                end
                if (o_sample_error !== want.error) begin
                    $error("sample_error: expected %0b, actual %0b", want.error,
                           o_sample_error);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_sample(input chan_t ch, input sample_t s);
        int gap;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            gap = $urandom_range(1, 40);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid   <= 1'b1;
        in_channel <= ch;
        in_sample  <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_avg_q.push_back(predict_mean(ch, s));
        sent_count++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_avg_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic sample_t pick_sample();
        sample_t s;
        case ($urandom_range(0, 9))
            0, 1:    s = '0;
            2:       s = sample_t'($urandom_range(1, 15));
            3:       s = 16'hFFFF;
            4:       s = sample_t'($urandom_range(16'hFF00, 16'hFFFF));
            default: s = sample_t'($urandom_range(0, 16'hFFFF));
        endcase
        return s;
    endfunction

    function automatic chan_t pick_channel();
        chan_t ch;
        if ($urandom_range(0, 19) == 0) begin
            ch = chan_t'(CHANNELS);
        end else begin
            ch = chan_t'($urandom_range(0, CHANNELS - 1));
        end
        return ch;
    endfunction

    task automatic test_empty_window();
        send_sample(2'd0, 16'd0);
        send_sample(2'd0, 16'd1);
        send_sample(2'd0, 16'd0);
    endtask

    task automatic test_full_scale();
        int i;
        send_sample(2'd1, 16'hFFFF);
        send_sample(2'd1, 16'd1);
        send_sample(2'd1, 16'd2);
        for (i = 0; i < WINDOW; i++) begin
            send_sample(2'd2, 16'hFFFF);
        end
        send_sample(2'd2, 16'd0);
    endtask

    task automatic test_bad_channel();
        send_sample(2'd3, 16'd12345);
        send_sample(2'd3, 16'd0);
        send_sample(2'd3, 16'hFFFF);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int    sent;
        int    burst;
        int    i;
        chan_t ch;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                send_sample(pick_channel(), sample_t'($urandom_range(0, 16'hFFFF)));
                sent++;
            end else begin
                ch    = chan_t'($urandom_range(0, CHANNELS - 1));
                burst = $urandom_range(1, WINDOW + 3);
                for (i = 0; i < burst; i++) begin
                    send_sample(ch, pick_sample());
                end
                sent += burst;
            end
        end
        wait_for_results();
    endtask

    task automatic test_drain_pause();
        int round;
        int i;
        send_idle_pct  = 0;
        recv_stall_pct = 27;
        for (round = 0; round < 5; round++) begin
            for (i = 0; i < 4; i++) begin
                send_sample(pick_channel(), pick_sample());
            end
            wait_for_results();
        end
    endtask

    initial begin
        foreach (chan_window[c, k]) chan_window[c][k] = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_window();
        test_full_scale();
        test_bad_channel();
        wait_for_results();

        test_random_traffic(0, 0);
        test_random_traffic(55, 0);
        test_random_traffic(0, 55);
        test_random_traffic(27, 27);
        test_drain_pause();

        recv_stall_pct = 0;
        wait_for_results();
        repeat (40) @(posedge i_clk);
        if (expected_avg_q.size() != 0) begin
            $error("Requests left without a result: %0d", expected_avg_q.size());
            fail_count++;
        end

        $display("Sent %0d requests over empty, full-scale, out-of-range and random traffic,",
                 sent_count);
        $display("with sender gaps and receiver stalls; checked %0d results, %0d mismatches.",
                 checked_count, fail_count);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
